// ===== hw/rtl/lgt_pkg.sv =====
// Package for the toroidal life board: sizes, widths, command codes and
// the per-row B3/S23 next-state function. No dependencies.
package lgt_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W    = $clog2(MAX_COLS + 1);
  localparam int KIND_W    = 2;
  localparam int IN_ROW_W  = 6;
  localparam int IN_COL_W  = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W     = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [NBR_W-1:0] NBR_BIRTH   = 4'd3;
  localparam logic [NBR_W-1:0] NBR_SURVIVE = 4'd2;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_GEN   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // bit c holds the left neighbour of column c, wrapping at the last used column
  function automatic row_t wrap_left(input row_t v, input logic [COL_W-1:0] ncm1);
    row_t l;
    l = {v[MAX_COLS-2:0], v[ncm1]};
    return l;
  endfunction

  function automatic row_t wrap_right(input row_t v, input logic [COL_W-1:0] ncm1);
    row_t r;
    r = {v[0], v[MAX_COLS-1:1]};
    r[ncm1] = v[0];
    return r;
  endfunction

  function automatic row_t life_row(input row_t up, input row_t cur, input row_t dn,
                                    input logic [COL_W-1:0] ncm1);
    row_t ul, ur, cl, cr, dl, dr, nxt;
    logic [NBR_W-1:0] n;
    ul = wrap_left(up, ncm1);
    ur = wrap_right(up, ncm1);
    cl = wrap_left(cur, ncm1);
    cr = wrap_right(cur, ncm1);
    dl = wrap_left(dn, ncm1);
    dr = wrap_right(dn, ncm1);
    for (int c = 0; c < MAX_COLS; c++) begin
      n = NBR_W'(ul[c]) + NBR_W'(up[c]) + NBR_W'(ur[c]) + NBR_W'(cl[c]) +
          NBR_W'(cr[c]) + NBR_W'(dl[c]) + NBR_W'(dn[c]) + NBR_W'(dr[c]);
      nxt[c] = cur[c] ? ((n == NBR_SURVIVE) || (n == NBR_BIRTH)) : (n == NBR_BIRTH);
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/life_generation_torus_core.sv =====
// Cell write/read: row read on acceptance; S_CELL registers the result when unstalled.
// Generation: S_GEN_UP/S_GEN_CUR fill line registers; S_GEN_ROW does one board
// row per cycle, one RAM read and one write a cycle; new items wait for idle.
// Reset (synchronous, rst_n low) marks every board row dead via per-row valid
// bits and sets both size registers to 64; no clearing pass is needed.
// Board storage, line registers and sequencer; depends on lgt_pkg.
module life_generation_torus_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lgt_pkg::KIND_W-1:0]     in_kind,
  input  logic [lgt_pkg::IN_ROW_W-1:0]   in_row,
  input  logic [lgt_pkg::IN_COL_W-1:0]   in_col,
  input  logic                           in_cell_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_read_value,
  output logic                           out_generation_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lgt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgt_pkg::CFG_W-1:0]      cfg_wdata
);
  import lgt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_GEN_UP,
    S_GEN_CUR,
    S_GEN_ROW,
    S_GEN_DONE
  } state_t;

  state_t                state_r;
  kind_t                 kind_r;
  logic [IN_ROW_W-1:0]   row_r;
  logic [IN_COL_W-1:0]   col_r;
  logic                  val_r;
  logic [ROW_W-1:0]      r_r;
  row_t                  up_r, cur_r, row0_r;
  logic                  out_valid_r, out_read_value_r, out_gen_done_r;
  logic [CFG_W-1:0]      rows_cfg_r, cols_cfg_r;

  row_t                  mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]   row_valid_r;
  row_t                  rd_data_r;
  logic                  rd_valid_r;

  logic                  rd_en, wr_en;
  logic [ROW_W-1:0]      rd_addr, wr_addr;
  row_t                  wr_data;

  logic [RCNT_W-1:0]     eff_rows;
  logic [CCNT_W-1:0]     eff_cols;
  logic [ROW_W-1:0]      last_row;
  logic [COL_W-1:0]      ncm1;
  row_t                  col_mask, rd_row, gen_dn, gen_new, cell_wr_row;
  logic                  on_board, in_accept, out_free;
  kind_t                 in_kind_e;

  assign in_kind_e = kind_t'(in_kind);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_read_value      = out_read_value_r;
  assign out_generation_done = out_gen_done_r;

  always_comb begin
    if (rows_cfg_r == '0) begin
      eff_rows = RCNT_W'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      eff_rows = RCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = RCNT_W'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      eff_cols = CCNT_W'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      eff_cols = CCNT_W'(MAX_COLS);
    end else begin
      eff_cols = CCNT_W'(cols_cfg_r);
    end
  end

  assign last_row = ROW_W'(eff_rows - RCNT_W'(1));
  assign ncm1     = COL_W'(eff_cols - CCNT_W'(1));
  assign on_board = (int'(row_r) < int'(eff_rows)) && (int'(col_r) < int'(eff_cols));
  assign rd_row   = rd_valid_r ? rd_data_r : '0;
  assign gen_dn   = (r_r == last_row) ? row0_r : rd_row;
  assign gen_new  = life_row(up_r, cur_r, gen_dn, ncm1);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(eff_cols));
    end
    cell_wr_row = rd_row;
    cell_wr_row[COL_W'(col_r)] = val_r;
  end

  // board RAM control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ROW_W'(in_row);
    wr_en   = 1'b0;
    wr_addr = r_r;
    wr_data = (gen_new & col_mask) | (cur_r & ~col_mask);
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_accept;
        rd_addr = (in_kind_e == KIND_GEN) ? last_row : ROW_W'(in_row);
      end
      S_GEN_UP: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_GEN_CUR: begin
        rd_en   = 1'b1;
        rd_addr = ROW_W'(1);
      end
      S_GEN_ROW: begin
        rd_en   = 1'b1;
        rd_addr = r_r + ROW_W'(2);
        wr_en   = 1'b1;
      end
      S_CELL: begin
        wr_en   = out_free && (kind_r == KIND_WRITE) && on_board;
        wr_addr = ROW_W'(row_r);
        wr_data = cell_wr_row;
      end
      S_GEN_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_RESET;
      cols_cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_wdata;
        REG_COLS: cols_cfg_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_CELL) && (state_r != S_GEN_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            kind_r  <= in_kind_e;
            row_r   <= in_row;
            col_r   <= in_col;
            val_r   <= in_cell_value;
            state_r <= (in_kind_e == KIND_GEN) ? S_GEN_UP : S_CELL;
          end
        end
        S_CELL: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= (kind_r == KIND_READ) && on_board && rd_row[COL_W'(col_r)];
            out_gen_done_r   <= 1'b0;
            state_r          <= S_IDLE;
          end
        end
        S_GEN_UP: begin
          up_r    <= rd_row;
          state_r <= S_GEN_CUR;
        end
        S_GEN_CUR: begin
          cur_r   <= rd_row;
          row0_r  <= rd_row;
          r_r     <= '0;
          state_r <= S_GEN_ROW;
        end
        S_GEN_ROW: begin
          up_r  <= cur_r;
          cur_r <= gen_dn;
          if (r_r == last_row) begin
            state_r <= S_GEN_DONE;
          end else begin
            r_r <= r_r + ROW_W'(1);
          end
        end
        S_GEN_DONE: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= 1'b0;
            out_gen_done_r   <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("board RAM read and write hit the same row");

  a_wr_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (RCNT_W'(wr_addr) < eff_rows))
    else $error("board write outside rows in use");

  a_valid_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_valid_r[$past(wr_addr)])
    else $error("written row not marked valid");

  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_read_value_r && out_gen_done_r))
    else $error("read value and generation done both set");
`endif

endmodule
